[design/spq_pkg.sv]
package spq_pkg;

    // Default number of slots in the chain.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Operation codes carried by the kind field.
    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    // Status codes of a result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // One stored entry.
    typedef struct packed {
        logic [7:0] prio;
        logic [7:0] chr;
    } entry_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

[design/spq_cell.sv]
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       left_yields,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       yields
);

    entry_t entry_reg;
    entry_t entry_next;

    // This slot gives way to a new entry when it is empty or holds a strictly
    // greater priority. Along the sorted chain this flag is a step from 0 to 1.
    assign yields = !occupied || (entry_reg.prio > ctrl.new_entry.prio);

    // An insert shifts yielding slots toward the tail and drops the new entry
    // into the first yielding slot. A removal shifts every slot toward the head.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq && yields)
        begin
            entry_next = left_yields ? left_entry : ctrl.new_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    // Slot payload needs no reset; only slots below the count are ever read.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[design/sorted_priority_queue.sv]
// A result appears in the output register in the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; the single output
// register stalls the input side while a result waits.
// Every slot of the cell chain compares against the new priority at once.
// Reset clears the entry count and the result valid; slot contents are not cleared.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       kind,
    input  logic [7:0] new_priority,
    input  logic [7:0] new_char,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_priority,
    output logic [7:0] out_char,
    output logic       out_valid,
    output logic [1:0] status,
    output logic [4:0] entry_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          res_valid_reg;
    logic          res_valid_next;
    entry_t        res_entry_reg;
    entry_t        res_entry_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;

    logic       accept;
    logic       full;
    logic       empty;
    logic       enq_ok;
    logic       deq_ok;
    cell_ctrl_t ctrl;

    entry_t cell_entry  [QUEUE_DEPTH];
    logic   cell_yields [QUEUE_DEPTH];

    // Input transfer handshake: the output register must be free or leaving.
    assign req_stall = res_valid_reg && res_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign enq_ok    = accept && (kind == KIND_ENQUEUE) && !full;
    assign deq_ok    = accept && (kind == KIND_DEQUEUE) && !empty;

    assign ctrl.enq            = enq_ok;
    assign ctrl.deq            = deq_ok;
    assign ctrl.new_entry.prio = new_priority;
    assign ctrl.new_entry.chr  = new_char;

    // The chain of cells; slot 0 is the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   occ;
        logic   left_y;
        entry_t left_e;
        entry_t right_e;

        assign occ = (count_reg > CW'(i));

        if (i == 0)
        begin : g_head
            assign left_y = 1'b0;
            assign left_e = ctrl.new_entry;
        end
        else
        begin : g_body
            assign left_y = cell_yields[i-1];
            assign left_e = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_e = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occ),
            .left_yields (left_y),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .yields      (cell_yields[i])
        );
    end

    // Entry count update.
    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (deq_ok)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    // Result formation for the accepted item.
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        res_entry_next = res_entry_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
            res_entry_next = '0;
            out_valid_next = 1'b0;
            status_next    = STATUS_OK;
            if (kind == KIND_ENQUEUE)
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
            end
            else if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                res_entry_next = cell_entry[0];
                out_valid_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        res_entry_reg <= res_entry_next;
        out_valid_reg <= out_valid_next;
        status_reg    <= status_next;
    end

    assign res_valid    = res_valid_reg;
    assign out_priority = res_entry_reg.prio;
    assign out_char     = res_entry_reg.chr;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_count  = 5'(count_reg);

    // The count never passes the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above queue depth");

    // A successful insert raises the count by one.
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        enq_ok |=> count_reg == $past(count_reg) + CNT_ONE)
        else $error("insert did not raise the count");

    // A returned entry always carries the ok status.
    a_deq_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_valid_reg) |-> status_reg == STATUS_OK)
        else $error("returned entry with error status");

    // The two head slots stay in priority order.
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg > CNT_ONE) |-> cell_entry[0].prio <= cell_entry[1].prio)
        else $error("head slots out of order");

endmodule
